// ----- src/wcs_pkg.sv -----
// ----------------------------------------------------------------------------
// wcs_pkg
// Shared types, codes and program step tables of the wash cycle sequencer.
// ----------------------------------------------------------------------------
package wcs_pkg;

    // Request codes carried in tuser
    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_ARM     = 2'd1;
    localparam logic [1:0] REQ_CONFIRM = 2'd2;

    // Reply codes
    localparam logic [1:0] REPLY_IDLE    = 2'd0;
    localparam logic [1:0] REPLY_ARMED   = 2'd1;
    localparam logic [1:0] REPLY_RUNNING = 2'd2;
    localparam logic [1:0] REPLY_DONE    = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_DRAIN_TAIL = 2'd0;
    localparam logic [1:0] REG_ALARM      = 2'd1;
    localparam logic [1:0] REG_SPM        = 2'd2;

    // Step code: kind in [6:4], minutes in [3:0]
    localparam logic [2:0] KIND_AGIT  = 3'd1;
    localparam logic [2:0] KIND_SOAK  = 3'd2;
    localparam logic [2:0] KIND_DRAIN = 3'd3;
    localparam logic [2:0] KIND_FILL  = 3'd4;

    localparam int NUM_PROGS   = 6;
    localparam int TABLE_STEPS = 16;

    localparam logic [4:0] PROG_LEN [0:NUM_PROGS-1] = '{5'd16, 5'd8, 5'd4, 5'd1, 5'd1, 5'd2};

    localparam logic [6:0] PROG_STEPS [0:NUM_PROGS-1][0:TABLE_STEPS-1] = '{
        '{7'h14, 7'h25, 7'h13, 7'h24, 7'h12, 7'h24, 7'h12, 7'h30,
          7'h13, 7'h24, 7'h12, 7'h30, 7'h12, 7'h24, 7'h12, 7'h30},
        '{7'h12, 7'h24, 7'h12, 7'h30, 7'h12, 7'h23, 7'h11, 7'h30,
          7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
        '{7'h11, 7'h21, 7'h11, 7'h30, 7'h00, 7'h00, 7'h00, 7'h00,
          7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
        '{7'h30, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
          7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
        '{7'h40, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
          7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
        '{7'h11, 7'h30, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
          7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00}
    };

    // Step count of a program; unknown programs have none
    function automatic logic [4:0] prog_len(input logic [2:0] prog);
        logic [4:0] len;
        len = 5'd0;
        if (prog < 3'(NUM_PROGS))
        begin
            len = PROG_LEN[prog];
        end
        return len;
    endfunction

    // Step code of a program step; zero outside the table
    function automatic logic [6:0] prog_step(input logic [2:0] prog, input logic [4:0] idx);
        logic [6:0] code;
        code = 7'd0;
        if ((prog < 3'(NUM_PROGS)) && !idx[4])
        begin
            code = PROG_STEPS[prog][idx[3:0]];
        end
        return code;
    endfunction

    typedef struct packed {
        logic [1:0] req_type;
        logic [2:0] program_code;
        logic [1:0] fill_level;
        logic       sensor_high;
        logic       sensor_mid;
        logic       sensor_low;
    } req_t;

    typedef struct packed {
        logic       water_on;
        logic       motor_on;
        logic       drain_on;
        logic       alarm_on;
        logic [1:0] reply_code;
        logic [3:0] step_number;
    } res_t;

    typedef struct packed {
        logic [7:0] drain_tail_seconds;
        logic [7:0] alarm_seconds;
        logic [5:0] seconds_per_minute;
    } cfg_t;

endpackage

// ----- src/wcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// wcs_ctrl
// Sequencer state and next-state logic; one item handled per enabled cycle.
// ----------------------------------------------------------------------------
module wcs_ctrl #(
    parameter int MAX_STEPS  = 16,
    parameter int TIMER_BITS = 9
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  wcs_pkg::req_t  req,
    input  wcs_pkg::cfg_t  cfg,
    output wcs_pkg::res_t  res
);

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_FILL       = 3'd1;
    localparam logic [2:0] PH_TIMED      = 3'd2;
    localparam logic [2:0] PH_DRAIN_WAIT = 3'd3;
    localparam logic [2:0] PH_DRAIN_TAIL = 3'd4;
    localparam logic [2:0] PH_ALARM      = 3'd5;

    localparam int PW = (TIMER_BITS > 10) ? TIMER_BITS : 10;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
    localparam logic [5:0] MAX_STEPS_W = 6'(MAX_STEPS);

    logic [2:0]            phase_reg, phase_next;
    logic                  armed_reg, armed_next;
    logic [2:0]            program_reg, program_next;
    logic [1:0]            level_reg, level_next;
    logic [4:0]            step_reg, step_next;
    logic [TIMER_BITS-1:0] time_reg, time_next;

    logic [6:0]            cur_code;
    logic [6:0]            enter_code;
    logic [6:0]            new_code;
    logic                  do_enter;
    logic                  finished;
    logic                  sens;
    logic                  expired;
    logic [TIMER_BITS-1:0] time_dec;
    logic [9:0]            minute_prod;
    logic [PW-1:0]         minute_wide;
    logic [TIMER_BITS-1:0] minute_time;

    assign cur_code    = wcs_pkg::prog_step(program_reg, step_reg);
    assign minute_prod = 10'(cur_code[3:0]) * 10'(cfg.seconds_per_minute);
    assign minute_wide = PW'(minute_prod);
    assign minute_time = (minute_wide > PW'(TIMER_MAX)) ? TIMER_MAX
                                                        : minute_wide[TIMER_BITS-1:0];

    // Span ends when at most one tick is left
    assign expired  = (time_reg <= TIMER_BITS'(1));
    assign time_dec = expired ? '0 : time_reg - TIMER_BITS'(1);

    always_comb
    begin
        case (level_reg)
            2'd0:    sens = req.sensor_high;
            2'd1:    sens = req.sensor_mid;
            default: sens = req.sensor_low;
        endcase
    end

    always_comb
    begin
        phase_next   = phase_reg;
        armed_next   = armed_reg;
        program_next = program_reg;
        level_next   = level_reg;
        step_next    = step_reg;
        time_next    = time_reg;
        do_enter     = 1'b0;
        finished     = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            if (req.req_type == wcs_pkg::REQ_ARM)
            begin
                armed_next = 1'b1;
            end
            else if ((req.req_type == wcs_pkg::REQ_CONFIRM) && armed_reg)
            begin
                armed_next   = 1'b0;
                program_next = req.program_code;
                level_next   = req.fill_level;
                step_next    = '0;
                time_next    = '0;
                do_enter     = 1'b1;
            end
        end
        else if (req.req_type == wcs_pkg::REQ_TICK)
        begin
            case (phase_reg)
                PH_FILL:
                begin
                    if (!sens)
                    begin
                        if (cur_code[6:4] == wcs_pkg::KIND_FILL)
                        begin
                            step_next = step_reg + 5'd1;
                            do_enter  = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_TIMED;
                            time_next  = minute_time;
                        end
                    end
                end
                PH_TIMED, PH_DRAIN_TAIL:
                begin
                    time_next = time_dec;
                    if (expired)
                    begin
                        step_next = step_reg + 5'd1;
                        do_enter  = 1'b1;
                    end
                end
                PH_DRAIN_WAIT:
                begin
                    if (req.sensor_low)
                    begin
                        phase_next = PH_DRAIN_TAIL;
                        time_next  = TIMER_BITS'(cfg.drain_tail_seconds);
                    end
                end
                PH_ALARM:
                begin
                    time_next = time_dec;
                    if (expired)
                    begin
                        phase_next = PH_IDLE;
                        step_next  = '0;
                        finished   = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        enter_code = wcs_pkg::prog_step(program_next, step_next);

        // Entry: past end -> alarm, drain step -> drain wait, else fill
        if (do_enter)
        begin
            if ((step_next >= wcs_pkg::prog_len(program_next))
                || ({1'b0, step_next} >= MAX_STEPS_W))
            begin
                phase_next = PH_ALARM;
                time_next  = TIMER_BITS'(cfg.alarm_seconds);
            end
            else if (enter_code[6:4] == wcs_pkg::KIND_DRAIN)
            begin
                phase_next = PH_DRAIN_WAIT;
            end
            else
            begin
                phase_next = PH_FILL;
            end
        end
    end

    assign new_code   = enter_code;

    always_comb
    begin
        res.water_on    = (phase_next == PH_FILL);
        res.motor_on    = (phase_next == PH_TIMED) && (new_code[6:4] == wcs_pkg::KIND_AGIT);
        res.drain_on    = (phase_next == PH_DRAIN_WAIT) || (phase_next == PH_DRAIN_TAIL);
        res.alarm_on    = (phase_next == PH_ALARM);
        res.step_number = ((phase_next == PH_IDLE) || (phase_next == PH_ALARM))
                          ? 4'd0 : step_next[3:0];
        if (finished)
        begin
            res.reply_code = wcs_pkg::REPLY_DONE;
        end
        else if (phase_next != PH_IDLE)
        begin
            res.reply_code = wcs_pkg::REPLY_RUNNING;
        end
        else if (armed_next)
        begin
            res.reply_code = wcs_pkg::REPLY_ARMED;
        end
        else
        begin
            res.reply_code = wcs_pkg::REPLY_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            armed_reg   <= 1'b0;
            program_reg <= '0;
            level_reg   <= '0;
            step_reg    <= '0;
            time_reg    <= '0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            armed_reg   <= armed_next;
            program_reg <= program_next;
            level_reg   <= level_next;
            step_reg    <= step_next;
            time_reg    <= time_next;
        end
    end

endmodule

// ----- src/wash_cycle_sequencer.sv -----
// ----------------------------------------------------------------------------
// wash_cycle_sequencer
// Wash-tank program sequencer with stream ports and an APB register port.
// ----------------------------------------------------------------------------
// Path: an accepted item passes the input register, then the result
//   register, before its result shows at m_axis.
// Throughput: one item per cycle unless m_axis stalls; the next-state logic
//   between the input register and the result register is a single pass.
// Reset (rst_n low, async): sequencer idle and unarmed, pipeline empty,
//   registers at drain tail 40, alarm 10, seconds per minute 60.
// ----------------------------------------------------------------------------
module wash_cycle_sequencer #(
    parameter int MAX_STEPS  = 16,
    parameter int TIMER_BITS = 9
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // program_code[2:0], fill_level[4:3],
                                        // sensor_high[5], sensor_mid[6], sensor_low[7]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // water_on[0], motor_on[1], drain_on[2],
                                        // alarm_on[3], reply_code[5:4],
                                        // step_number[9:6], zeros above
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Register file
    logic [7:0] drain_tail_reg;
    logic [7:0] alarm_reg;
    logic [5:0] spm_reg;
    logic       cfg_write;
    wcs_pkg::cfg_t cfg;

    // Pipeline
    logic          in_valid_reg;
    wcs_pkg::req_t in_item_reg;
    logic          out_valid_reg;
    wcs_pkg::res_t out_item_reg;
    wcs_pkg::res_t step_res;
    logic          advance;
    logic          in_take;

    // ------------------------------------------------------------------
    // APB registers; word index in paddr[3:2], always ready
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_tail_reg <= 8'd40;
            alarm_reg      <= 8'd10;
            spm_reg        <= 6'd60;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                wcs_pkg::REG_DRAIN_TAIL: drain_tail_reg <= pwdata[7:0];
                wcs_pkg::REG_ALARM:      alarm_reg      <= pwdata[7:0];
                wcs_pkg::REG_SPM:        spm_reg        <= pwdata[5:0];
                default:                 ;  // unmapped word, write dropped
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            wcs_pkg::REG_DRAIN_TAIL: prdata = {24'd0, drain_tail_reg};
            wcs_pkg::REG_ALARM:      prdata = {24'd0, alarm_reg};
            wcs_pkg::REG_SPM:        prdata = {26'd0, spm_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    assign cfg.drain_tail_seconds = drain_tail_reg;
    assign cfg.alarm_seconds      = alarm_reg;
    assign cfg.seconds_per_minute = spm_reg;

    // ------------------------------------------------------------------
    // Handshake: the held item moves into the result register whenever
    // that register is empty or being drained this cycle. The input
    // side refills in the same cycle, so items stream back to back.
    // ------------------------------------------------------------------
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_take || (in_valid_reg && !advance);
            out_valid_reg <= advance || (out_valid_reg && !m_axis_tready);
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.req_type     <= s_axis_tuser;
            in_item_reg.program_code <= s_axis_tdata[2:0];
            in_item_reg.fill_level   <= s_axis_tdata[4:3];
            in_item_reg.sensor_high  <= s_axis_tdata[5];
            in_item_reg.sensor_mid   <= s_axis_tdata[6];
            in_item_reg.sensor_low   <= s_axis_tdata[7];
        end
        if (advance)
        begin
            out_item_reg <= step_res;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: state commits only when the item moves forward
    // ------------------------------------------------------------------
    wcs_ctrl #(
        .MAX_STEPS  (MAX_STEPS),
        .TIMER_BITS (TIMER_BITS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .req     (in_item_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0,
                            out_item_reg.step_number,
                            out_item_reg.reply_code,
                            out_item_reg.alarm_on,
                            out_item_reg.drain_on,
                            out_item_reg.motor_on,
                            out_item_reg.water_on};

endmodule
